// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 32;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SIZE_W = 16;
	localparam int TOP_W  = $clog2(HEAP_BYTES + 1);
	localparam int NEED_W = TOP_W + 1;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NULL    = 2'd1;
	localparam logic [1:0] STAT_NOSPACE = 2'd2;
	localparam logic [1:0] STAT_BADH    = 2'd3;

	// search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              fit_found;
		logic [IDX_W-1:0]  fit_idx;
		logic [SIZE_W-1:0] fit_off;
		logic [SIZE_W-1:0] fit_size;
		logic              h_in_use;
		logic [SIZE_W-1:0] h_size;
		logic [SIZE_W-1:0] h_off;
	} token_t;

	// values every cell compares against during a scan
	typedef struct packed {
		logic [SIZE_W-1:0] req;
		logic [IDX_W-1:0]  bi;
		logic [CNT_W-1:0]  count;
	} scan_ctx_t;

	// table update broadcast at the end of a transaction
	typedef struct packed {
		logic              set_en;
		logic [IDX_W-1:0]  set_idx;
		logic              clr_en;
		logic [IDX_W-1:0]  clr_idx;
		logic              app_en;
		logic [IDX_W-1:0]  app_idx;
		logic [SIZE_W-1:0] app_size;
		logic [SIZE_W-1:0] app_off;
	} cell_wr_t;

endpackage

// ===== src/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry plus one stage of the search token chain.
// ----------------------------------------------------------------------------
module ffba_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ffba_pkg::IDX_W-1:0] cell_idx,
	input  ffba_pkg::scan_ctx_t       ctx,
	input  ffba_pkg::cell_wr_t        wr,
	input  ffba_pkg::token_t          tok_in,
	output ffba_pkg::token_t          tok_out
);

	logic [ffba_pkg::SIZE_W-1:0] size_q;
	logic [ffba_pkg::SIZE_W-1:0] off_q;
	logic                        in_use_q;
	logic                        valid_q;
	ffba_pkg::token_t            data_q;
	ffba_pkg::token_t            data_n;
	logic                        live;

	assign live = {1'b0, cell_idx} < ctx.count;

	always_comb begin
		data_n = tok_in;
		if (tok_in.valid && live) begin
			if (!in_use_q && size_q >= ctx.req && !tok_in.fit_found) begin
				data_n.fit_found = 1'b1;
				data_n.fit_idx   = cell_idx;
				data_n.fit_off   = off_q;
				data_n.fit_size  = size_q;
			end
			if (cell_idx == ctx.bi) begin
				data_n.h_in_use = in_use_q;
				data_n.h_size   = size_q;
				data_n.h_off    = off_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_n;
		if (wr.app_en && wr.app_idx == cell_idx) begin
			size_q   <= wr.app_size;
			off_q    <= wr.app_off;
			in_use_q <= 1'b1;
		end else if (wr.set_en && wr.set_idx == cell_idx) begin
			in_use_q <= 1'b1;
		end else if (wr.clr_en && wr.clr_idx == cell_idx) begin
			in_use_q <= 1'b0;
		end
	end

	always_comb begin
		tok_out       = data_q;
		tok_out.valid = valid_q;
	end

endmodule

// ===== src/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: launches the search token, decides the outcome and commits it.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   operation,
	input  logic [ffba_pkg::SIZE_W-1:0]  request_size,
	input  logic                         handle_valid,
	input  logic [ffba_pkg::IDX_W-1:0]   block_index,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [ffba_pkg::IDX_W-1:0]   result_index,
	output logic [ffba_pkg::SIZE_W-1:0]  data_offset,
	output logic [ffba_pkg::SIZE_W-1:0]  block_capacity,
	output logic                         tail_released,
	output ffba_pkg::scan_ctx_t          ctx,
	output ffba_pkg::cell_wr_t           wr,
	output ffba_pkg::token_t             tok_head,
	input  ffba_pkg::token_t             tok_tail
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                          state_q;
	logic                          inj_q;
	logic [1:0]                    op_q;
	logic [ffba_pkg::SIZE_W-1:0]   req_q;
	logic                          hv_q;
	logic [ffba_pkg::IDX_W-1:0]    bi_q;
	logic [ffba_pkg::CNT_W-1:0]    count_q;
	logic [ffba_pkg::TOP_W-1:0]    top_q;
	logic [ffba_pkg::NEED_W-1:0]   need_q;
	logic                          done_q;
	logic [1:0]                    status_q;
	logic [ffba_pkg::IDX_W-1:0]    idx_q;
	logic [ffba_pkg::SIZE_W-1:0]   off_q;
	logic [ffba_pkg::SIZE_W-1:0]   cap_q;
	logic                          rel_q;

	logic                          accept;
	logic                          commit;
	logic                          req_zero;
	logic                          can_app;
	logic                          alloc_ok;
	logic                          tail_hit;
	logic [ffba_pkg::IDX_W-1:0]    a_idx;
	logic [ffba_pkg::SIZE_W-1:0]   a_off;
	logic [ffba_pkg::SIZE_W-1:0]   a_size;
	logic [ffba_pkg::TOP_W-1:0]    pop_top;
	logic                          do_alloc;
	logic                          grant;
	logic [1:0]                    st_n;
	logic [ffba_pkg::IDX_W-1:0]    idx_n;
	logic [ffba_pkg::SIZE_W-1:0]   off_n;
	logic [ffba_pkg::SIZE_W-1:0]   cap_n;
	logic                          rel_n;
	logic [ffba_pkg::CNT_W-1:0]    count_n;
	logic [ffba_pkg::TOP_W-1:0]    top_n;

	assign accept = start && !busy;
	assign busy   = state_q == ST_SCAN;
	assign commit = state_q == ST_SCAN && tok_tail.valid;

	assign ctx.req   = req_q;
	assign ctx.bi    = bi_q;
	assign ctx.count = count_q;

	always_comb begin
		tok_head       = '0;
		tok_head.valid = inj_q;
	end

	assign req_zero = req_q == '0;
	assign can_app  = count_q < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)
		&& need_q <= ffba_pkg::NEED_W'(ffba_pkg::HEAP_BYTES);
	assign alloc_ok = !req_zero && (tok_tail.fit_found || can_app);
	assign tail_hit = {1'b0, bi_q} + ffba_pkg::CNT_W'(1) == count_q;
	assign a_idx    = tok_tail.fit_found ? tok_tail.fit_idx : count_q[ffba_pkg::IDX_W-1:0];
	assign a_off    = tok_tail.fit_found ? tok_tail.fit_off : top_q[ffba_pkg::SIZE_W-1:0];
	assign a_size   = tok_tail.fit_found ? tok_tail.fit_size : req_q;
	assign pop_top  = top_q - ffba_pkg::TOP_W'(ffba_pkg::HEADER_BYTES)
		- ffba_pkg::TOP_W'(tok_tail.h_size);

	always_comb begin
		do_alloc = 1'b0;
		grant    = 1'b0;
		st_n     = ffba_pkg::STAT_OK;
		idx_n    = '0;
		off_n    = '0;
		cap_n    = '0;
		rel_n    = 1'b0;
		count_n  = count_q;
		top_n    = top_q;
		wr       = '0;
		unique case (op_q)
			ffba_pkg::OP_ALLOC: begin
				do_alloc = 1'b1;
			end
			ffba_pkg::OP_FREE: begin
				if (!hv_q) begin
					st_n = ffba_pkg::STAT_OK;
				end else if (!tok_tail.h_in_use) begin
					st_n = ffba_pkg::STAT_BADH;
				end else begin
					wr.clr_en  = 1'b1;
					wr.clr_idx = bi_q;
					idx_n      = bi_q;
					if (tail_hit) begin
						rel_n   = 1'b1;
						count_n = {1'b0, bi_q};
						top_n   = pop_top;
					end
				end
			end
			ffba_pkg::OP_RESIZE: begin
				if (!hv_q || req_zero) begin
					do_alloc = 1'b1;
				end else if (!tok_tail.h_in_use) begin
					st_n = ffba_pkg::STAT_BADH;
				end else if (tok_tail.h_size >= req_q) begin
					idx_n = bi_q;
					off_n = tok_tail.h_off + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES);
					cap_n = tok_tail.h_size;
				end else if (!alloc_ok) begin
					st_n = ffba_pkg::STAT_NOSPACE;
				end else begin
					// grow: take the new block, then release the old one
					grant      = 1'b1;
					wr.clr_en  = 1'b1;
					wr.clr_idx = bi_q;
					if (tok_tail.fit_found && tail_hit) begin
						rel_n   = 1'b1;
						count_n = {1'b0, bi_q};
						top_n   = pop_top;
					end
				end
			end
			default: begin
				st_n = ffba_pkg::STAT_NULL;
			end
		endcase
		if (do_alloc) begin
			if (req_zero) begin
				st_n = ffba_pkg::STAT_NULL;
			end else if (!alloc_ok) begin
				st_n = ffba_pkg::STAT_NOSPACE;
			end else begin
				grant = 1'b1;
			end
		end
		if (grant) begin
			idx_n = a_idx;
			off_n = a_off + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES);
			cap_n = a_size;
			if (tok_tail.fit_found) begin
				wr.set_en  = 1'b1;
				wr.set_idx = a_idx;
			end else begin
				wr.app_en   = 1'b1;
				wr.app_idx  = a_idx;
				wr.app_size = req_q;
				wr.app_off  = a_off;
				count_n     = count_q + ffba_pkg::CNT_W'(1);
				top_n       = need_q[ffba_pkg::TOP_W-1:0];
			end
		end
		if (!commit) begin
			wr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			inj_q   <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
			top_q   <= '0;
		end else begin
			inj_q  <= accept;
			done_q <= commit;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_tail.valid) begin
						state_q <= ST_IDLE;
						count_q <= count_n;
						top_q   <= top_n;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			req_q <= request_size;
			hv_q  <= handle_valid;
			bi_q  <= block_index;
		end
		need_q <= ffba_pkg::NEED_W'(top_q) + ffba_pkg::NEED_W'(ffba_pkg::HEADER_BYTES)
			+ ffba_pkg::NEED_W'(req_q);
		if (commit) begin
			status_q <= st_n;
			idx_q    <= idx_n;
			off_q    <= off_n;
			cap_q    <= cap_n;
			rel_q    <= rel_n;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_index   = idx_q;
	assign data_offset    = off_q;
	assign block_capacity = cap_q;
	assign tail_released  = rel_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
		else $error("block count above table depth");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= ffba_pkg::TOP_W'(ffba_pkg::HEAP_BYTES))
		else $error("heap top above heap size");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_tail.valid |-> state_q == ST_SCAN)
		else $error("search token arrived outside a scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE && !inj_q)
		else $error("result strobe while a search is running");

	a_accept_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> inj_q && state_q == ST_SCAN)
		else $error("accepted transaction did not launch a search");

endmodule

// ===== src/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator built as a chain of table cells.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  request   | start, busy        | operation, request_size, handle_valid,
//            |                    | block_index
//  result    | done (1-cycle)     | status, result_index, data_offset,
//            |                    | block_capacity, tail_released
//
//  In a transaction the search token walks the cell chain one cell per cycle,
//  then the table update is committed and the result registered, and done is
//  high the cycle after the commit.
//  busy is high from the accept edge until the commit edge; a new transaction
//  may start in the cycle that done is high.
//  Reset (arst_n low) empties the table and zeroes the heap top at once; the
//  entry contents themselves are not cleared. done cannot be stalled.
//
module first_fit_block_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   operation,
	input  logic [ffba_pkg::SIZE_W-1:0]  request_size,
	input  logic                         handle_valid,
	input  logic [ffba_pkg::IDX_W-1:0]   block_index,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [ffba_pkg::IDX_W-1:0]   result_index,
	output logic [ffba_pkg::SIZE_W-1:0]  data_offset,
	output logic [ffba_pkg::SIZE_W-1:0]  block_capacity,
	output logic                         tail_released
);

	// token links: link[g] feeds cell g, link[MAX_BLOCKS] comes out of the last cell
	ffba_pkg::token_t    link [ffba_pkg::MAX_BLOCKS+1];
	ffba_pkg::scan_ctx_t ctx;
	ffba_pkg::cell_wr_t  wr;

	// sequencer: holds the transaction, count and heap top, and decides the update
	ffba_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.request_size   (request_size),
		.handle_valid   (handle_valid),
		.block_index    (block_index),
		.done           (done),
		.status         (status),
		.result_index   (result_index),
		.data_offset    (data_offset),
		.block_capacity (block_capacity),
		.tail_released  (tail_released),
		.ctx            (ctx),
		.wr             (wr),
		.tok_head       (link[0]),
		.tok_tail       (link[ffba_pkg::MAX_BLOCKS])
	);

	// one cell per table entry; the token picks up the first fit and the
	// named block's fields as it passes, and the update is broadcast by index
	for (genvar g = 0; g < ffba_pkg::MAX_BLOCKS; g++) begin : g_cell
		ffba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (ffba_pkg::IDX_W'(g)),
			.ctx      (ctx),
			.wr       (wr),
			.tok_in   (link[g]),
			.tok_out  (link[g+1])
		);
	end

endmodule
